/* rtl/core/dq_pkg.sv */
package dq_pkg;

  localparam int DEPTH_DEF = 16;

  localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [2:0] CMD_POP_BACK   = 3'd3;
  localparam logic [2:0] CMD_DUMP       = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef enum logic {
    S_IDLE,
    S_DUMP
  } dq_state_t;

  typedef struct packed {
    logic        [2:0]  cmd;
    logic signed [31:0] push_value;
  } in_item_t;

  typedef struct packed {
    logic        [1:0]  status;
    logic signed [31:0] out_value;
    logic               last;
  } out_item_t;

endpackage

/* rtl/core/dq_mem.sv */
module dq_mem #(
  parameter int DEPTH = dq_pkg::DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic                 rd_en,
  input  logic [AW-1:0]        addr,
  input  logic signed [31:0]   wr_data,
  output logic signed [31:0]   rd_data
);

  logic signed [31:0] mem [DEPTH];
  logic signed [31:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/core/dq_ctrl.sv */
module dq_ctrl #(
  parameter int DEPTH = dq_pkg::DEPTH_DEF,
  parameter int PW    = $clog2(DEPTH),
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  dq_pkg::in_item_t   in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output dq_pkg::out_item_t  out_data,
  output logic               mem_wr_en,
  output logic               mem_rd_en,
  output logic [PW-1:0]      mem_addr,
  output logic signed [31:0] mem_wr_data,
  input  logic signed [31:0] mem_rd_data
);

  dq_pkg::dq_state_t state_r, state_nxt;
  logic [PW-1:0]      front_r, front_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [CW-1:0]      dump_idx_r, dump_idx_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [1:0]         status_r, status_nxt;
  logic               last_r, last_nxt;
  logic signed [31:0] value_r, value_nxt;
  logic               from_mem_r, from_mem_nxt;

  logic out_free;
  logic in_acc;
  logic is_empty;
  logic is_full;
  logic dump_last;

  function automatic logic [PW-1:0] ring_add(logic [PW-1:0] base, logic [CW-1:0] off);
    logic [CW:0] s;
    s = (CW+1)'(base) + (CW+1)'(off);
    if (s >= (CW+1)'(DEPTH)) begin
      s = s - (CW+1)'(DEPTH);
    end
    return s[PW-1:0];
  endfunction

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = !((state_r == dq_pkg::S_IDLE) && out_free);
  assign in_acc    = in_valid && !in_stall;
  assign is_empty  = (count_r == '0);
  assign is_full   = (count_r == CW'(DEPTH));
  assign dump_last = (dump_idx_r == count_r - CW'(1));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      dq_pkg::S_IDLE: begin
        if (in_acc && in_data.cmd == dq_pkg::CMD_DUMP && count_r > CW'(1)) begin
          state_nxt = dq_pkg::S_DUMP;
        end
      end
      dq_pkg::S_DUMP: begin
        if (out_free && dump_last) begin
          state_nxt = dq_pkg::S_IDLE;
        end
      end
      default: state_nxt = dq_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    front_nxt     = front_r;
    count_nxt     = count_r;
    dump_idx_nxt  = dump_idx_r;
    out_valid_nxt = out_free ? 1'b0 : out_valid_r;
    status_nxt    = status_r;
    last_nxt      = last_r;
    value_nxt     = value_r;
    from_mem_nxt  = from_mem_r;
    mem_wr_en     = 1'b0;
    mem_rd_en     = 1'b0;
    mem_addr      = front_r;
    mem_wr_data   = in_data.push_value;
    unique case (state_r)
      dq_pkg::S_IDLE: begin
        if (in_acc) begin
          last_nxt = 1'b1;
          unique case (in_data.cmd) inside
            dq_pkg::CMD_PUSH_FRONT, dq_pkg::CMD_PUSH_BACK: begin
              out_valid_nxt = 1'b1;
              value_nxt     = in_data.push_value;
              from_mem_nxt  = 1'b0;
              if (is_full) begin
                status_nxt = dq_pkg::ST_FULL;
              end else begin
                status_nxt = dq_pkg::ST_OK;
                mem_wr_en  = 1'b1;
                count_nxt  = count_r + CW'(1);
                if (in_data.cmd == dq_pkg::CMD_PUSH_FRONT) begin
                  front_nxt = (front_r == '0) ? PW'(DEPTH - 1) : front_r - PW'(1);
                  mem_addr  = front_nxt;
                end else begin
                  mem_addr = ring_add(front_r, count_r);
                end
              end
            end
            dq_pkg::CMD_POP_FRONT, dq_pkg::CMD_POP_BACK: begin
              out_valid_nxt = 1'b1;
              if (is_empty) begin
                status_nxt   = dq_pkg::ST_EMPTY;
                value_nxt    = '0;
                from_mem_nxt = 1'b0;
              end else begin
                status_nxt   = dq_pkg::ST_OK;
                from_mem_nxt = 1'b1;
                mem_rd_en    = 1'b1;
                count_nxt    = count_r - CW'(1);
                if (in_data.cmd == dq_pkg::CMD_POP_FRONT) begin
                  mem_addr  = front_r;
                  front_nxt = ring_add(front_r, CW'(1));
                end else begin
                  mem_addr = ring_add(front_r, count_r - CW'(1));
                end
              end
            end
            dq_pkg::CMD_DUMP: begin
              out_valid_nxt = 1'b1;
              if (is_empty) begin
                status_nxt   = dq_pkg::ST_EMPTY;
                value_nxt    = '0;
                from_mem_nxt = 1'b0;
              end else begin
                status_nxt   = dq_pkg::ST_OK;
                from_mem_nxt = 1'b1;
                mem_rd_en    = 1'b1;
                mem_addr     = front_r;
                last_nxt     = (count_r == CW'(1));
                dump_idx_nxt = CW'(1);
              end
            end
            default: out_valid_nxt = 1'b0;
          endcase
        end
      end
      dq_pkg::S_DUMP: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          status_nxt    = dq_pkg::ST_OK;
          from_mem_nxt  = 1'b1;
          mem_rd_en     = 1'b1;
          mem_addr      = ring_add(front_r, dump_idx_r);
          last_nxt      = dump_last;
          dump_idx_nxt  = dump_idx_r + CW'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dq_pkg::S_IDLE;
      front_r     <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      front_r     <= front_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dump_idx_r <= dump_idx_nxt;
    status_r   <= status_nxt;
    last_r     <= last_nxt;
    value_r    <= value_nxt;
    from_mem_r <= from_mem_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_data.status    = status_r;
  assign out_data.out_value = from_mem_r ? mem_rd_data : value_r;
  assign out_data.last      = last_r;

endmodule

/* rtl/core/double_ended_queue.sv */
// Channel   Handshake               Payload
// in        in_valid / in_stall     in_data  (cmd, push_value)
// out       out_valid / out_stall   out_data (status, out_value, last)
//
// Push, pop and empty/full reports: the result shows the cycle after the
// transfer, and a new command can be taken meanwhile. Pops read the ring
// store through its registered read port. A dump streams one entry per
// cycle from the store's single port while the output does not stall, and
// holds the input until its last entry is read. Output stalls hold it too.
// Synchronous active-low reset empties the queue; no clearing pass.
module double_ended_queue #(
  parameter int DEPTH = dq_pkg::DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  dq_pkg::in_item_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output dq_pkg::out_item_t out_data
);

  localparam int PW = $clog2(DEPTH);

  logic               mem_wr_en;
  logic               mem_rd_en;
  logic [PW-1:0]      mem_addr;
  logic signed [31:0] mem_wr_data;
  logic signed [31:0] mem_rd_data;

  dq_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .mem_wr_en  (mem_wr_en),
    .mem_rd_en  (mem_rd_en),
    .mem_addr   (mem_addr),
    .mem_wr_data(mem_wr_data),
    .mem_rd_data(mem_rd_data)
  );

  dq_mem #(
    .DEPTH(DEPTH)
  ) u_mem (
    .clk    (clk),
    .wr_en  (mem_wr_en),
    .rd_en  (mem_rd_en),
    .addr   (mem_addr),
    .wr_data(mem_wr_data),
    .rd_data(mem_rd_data)
  );

endmodule
